// File: sv/qdot_pkg.sv
// ----------------------------------------------------------------------------
// qdot_pkg
// Shared types and constants for the Q4 x Q8 block dot product.
// ----------------------------------------------------------------------------
package qdot_pkg;

    localparam int BLOCK_SIZE = 32;
    localparam int LANE_ELEMS = 8;
    localparam int LANES      = BLOCK_SIZE / LANE_ELEMS;
    localparam int MAX_ROWS   = 4096;

    localparam logic [3:0] NIBBLE_MASK = 4'h0f;
    localparam int         Q4_OFFSET   = 8;

    // widths of the partial results
    localparam int LANE_W = 15;   // eight 4x8 products
    localparam int ISUM_W = 17;   // sum of four lanes
    localparam int SC_W   = 16;
    localparam int P1_W   = ISUM_W + SC_W;
    localparam int TERM_W = P1_W + SC_W;
    localparam int ACC_W  = 64;
    localparam int ROW_W  = 12;

    typedef logic signed [LANE_W-1:0] lane_sum_t;
    typedef logic signed [TERM_W-1:0] term_t;

    typedef struct packed {
        logic valid;
        logic last_block;
        logic last_row;
    } ctl_t;

endpackage

// File: sv/qdot_blk_if.sv
// ----------------------------------------------------------------------------
// qdot_blk_if
// Input channel: one 32-element quantised block per transfer.
// ----------------------------------------------------------------------------
interface qdot_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] weight_lo;
    logic [63:0] weight_hi;
    logic [63:0] act_0;
    logic [63:0] act_1;
    logic [63:0] act_2;
    logic [63:0] act_3;
    logic signed [15:0] weight_scale;
    logic signed [15:0] act_scale;
    logic        last_block;
    logic        last_row;

    modport source (output valid, weight_lo, weight_hi, act_0, act_1, act_2, act_3,
                    weight_scale, act_scale, last_block, last_row, input ready);
    modport sink   (input valid, weight_lo, weight_hi, act_0, act_1, act_2, act_3,
                    weight_scale, act_scale, last_block, last_row, output ready);
endinterface

// File: sv/qdot_res_if.sv
// ----------------------------------------------------------------------------
// qdot_res_if
// Output channel: one row result per transfer.
// ----------------------------------------------------------------------------
interface qdot_res_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] dot_sum;
    logic [11:0]        row_index;
    logic               saturated;

    modport source (output valid, dot_sum, row_index, saturated, input ready);
    modport sink   (input valid, dot_sum, row_index, saturated, output ready);
endinterface

// File: sv/qdot_lane.sv
// ----------------------------------------------------------------------------
// qdot_lane
// One lane: eight Q4 x Q8 products summed and registered.
// ----------------------------------------------------------------------------
module qdot_lane
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [31:0]            weights,
    input  logic [63:0]            acts,
    output qdot_pkg::lane_sum_t    psum_reg
);

    qdot_pkg::lane_sum_t psum_next;

    always_comb
    begin
        logic [7:0]        wbyte;
        logic [3:0]        nib;
        logic signed [4:0] q4;
        logic signed [7:0] a8;
        logic signed [12:0] prod;
        psum_next = '0;
        for (int i = 0; i < qdot_pkg::LANE_ELEMS; i++)
        begin
            wbyte = weights[8*(i/2) +: 8];
            nib   = (i % 2 == 1) ? wbyte[7:4] : (wbyte[3:0] & qdot_pkg::NIBBLE_MASK);
            q4    = $signed({1'b0, nib}) - 5'(qdot_pkg::Q4_OFFSET);
            a8    = $signed(acts[8*i +: 8]);
            prod  = 13'(q4) * 13'(a8);
            psum_next = psum_next + qdot_pkg::LANE_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psum_reg <= psum_next;
        end
    end

endmodule

// File: sv/qdot_merge.sv
// ----------------------------------------------------------------------------
// qdot_merge
// Merges the lane sums and applies both block scales, one step per stage.
// ----------------------------------------------------------------------------
module qdot_merge
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  qdot_pkg::lane_sum_t        psum [qdot_pkg::LANES],
    input  logic signed [15:0]         weight_scale,
    input  logic signed [15:0]         act_scale,
    input  qdot_pkg::ctl_t             ctl_in,
    output qdot_pkg::term_t            term_reg,
    output qdot_pkg::ctl_t             ctl_out
);

    logic signed [qdot_pkg::ISUM_W-1:0] isum_reg;
    logic signed [qdot_pkg::ISUM_W-1:0] isum_next;
    logic signed [qdot_pkg::P1_W-1:0]   p1_reg;
    logic signed [15:0]                 ws2_reg, as2_reg, as3_reg;
    qdot_pkg::ctl_t                     ctl2_reg, ctl3_reg, ctl4_reg;

    always_comb
    begin
        isum_next = '0;
        for (int l = 0; l < qdot_pkg::LANES; l++)
        begin
            isum_next = isum_next + qdot_pkg::ISUM_W'(psum[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            ctl2_reg <= ctl_in;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            isum_reg <= isum_next;
            ws2_reg  <= weight_scale;
            as2_reg  <= act_scale;
            p1_reg   <= qdot_pkg::P1_W'(isum_reg) * qdot_pkg::P1_W'(ws2_reg);
            as3_reg  <= as2_reg;
            term_reg <= qdot_pkg::TERM_W'(p1_reg) * qdot_pkg::TERM_W'(as3_reg);
        end
    end

    assign ctl_out = ctl4_reg;

endmodule

// File: sv/qdot_accum.sv
// ----------------------------------------------------------------------------
// qdot_accum
// Saturating row accumulator, row counter and result register.
// ----------------------------------------------------------------------------
module qdot_accum
(
    input  logic               clk,
    input  logic               rst_n,
    input  qdot_pkg::term_t    term,
    input  qdot_pkg::ctl_t     ctl,
    output logic               adv,
    qdot_res_if.source         res
);

    localparam logic signed [qdot_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(qdot_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [qdot_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(qdot_pkg::ACC_W-1){1'b0}}};

    logic signed [qdot_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                              sat_reg, sat_next;
    logic [qdot_pkg::ROW_W-1:0]        row_reg, row_next;
    logic                              res_valid_reg, res_valid_next;
    logic signed [qdot_pkg::ACC_W-1:0] res_sum_reg;
    logic [qdot_pkg::ROW_W-1:0]        res_row_reg;
    logic                              res_sat_reg;

    logic signed [qdot_pkg::ACC_W-1:0] term64, sum, acc_new;
    logic                              ovf, commit, emit, wrap;
    logic [qdot_pkg::ROW_W:0]          row_inc;

    // a row result may only land once the result register is free or being drained
    assign adv    = !(res_valid_reg && !res.ready && ctl.valid && ctl.last_block);
    assign commit = ctl.valid && adv;
    assign emit   = commit && ctl.last_block;

    assign term64  = qdot_pkg::ACC_W'(term);
    assign sum     = acc_reg + term64;
    assign ovf     = (acc_reg[qdot_pkg::ACC_W-1] == term64[qdot_pkg::ACC_W-1]) &&
                     (sum[qdot_pkg::ACC_W-1] != acc_reg[qdot_pkg::ACC_W-1]);
    assign acc_new = ovf ? (acc_reg[qdot_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;

    assign row_inc = {1'b0, row_reg} + (qdot_pkg::ROW_W+1)'(1);
    assign wrap    = ctl.last_row || (32'(row_inc) >= 32'(qdot_pkg::MAX_ROWS));

    always_comb
    begin
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        row_next       = row_reg;
        res_valid_next = res_valid_reg && !res.ready;
        if (commit)
        begin
            acc_next = acc_new;
            sat_next = sat_reg || ovf;
        end
        if (emit)
        begin
            acc_next       = '0;
            sat_next       = 1'b0;
            row_next       = wrap ? '0 : row_inc[qdot_pkg::ROW_W-1:0];
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_sum_reg <= acc_new;
            res_row_reg <= row_reg;
            res_sat_reg <= sat_reg || ovf;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.dot_sum   = res_sum_reg;
    assign res.row_index = res_row_reg;
    assign res.saturated = res_sat_reg;

`ifndef ASSERT_OFF
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (acc_reg == '0) && !sat_reg && res_valid_reg)
        else $error("accumulator not cleared after row result");

    a_last_row_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        emit && ctl.last_row |=> row_reg == '0)
        else $error("row counter did not return to zero on final row");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(acc_reg) && $stable(row_reg))
        else $error("accumulator state moved without a block");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !emit)
        else $error("pending row result overwritten");
`endif

endmodule

// File: sv/q4_q8_block_dot_product.sv
// ----------------------------------------------------------------------------
// q4_q8_block_dot_product
// Streaming Q4 x Q8 block dot product with saturating row accumulation.
// ----------------------------------------------------------------------------
// Usage:
//   blk carries one 32-element block per transfer: packed 4-bit weights,
//   32 signed 8-bit activations, two signed 16-bit scales and the row flags.
//   res carries one result per row, on the transfer of a block with
//   last_block set: the scaled row sum, the row index and a saturation flag.
//   Throughput: one block per cycle while blk.ready is high. Four lanes of
//   eight multipliers form the integer sum, which then passes a merge adder
//   and two scale multipliers, each in its own stage.
//   After the last block of a row leaves the activation-scale stage, the
//   row result is registered in the result register and offered on res.
//   Reset clears the accumulator, saturation flag, row counter and pipeline
//   control flags; blocks are taken from the first cycle after reset.
//   A stalled receiver holds the pending result; blocks keep flowing until
//   a second row result reaches the accumulator stage, then blk.ready drops
//   until the pending result is taken.
// ----------------------------------------------------------------------------
module q4_q8_block_dot_product
(
    input  logic       clk,
    input  logic       rst_n,
    qdot_blk_if.sink   blk,
    qdot_res_if.source res
);

    logic                     adv;
    logic [127:0]             wbytes;
    logic [3:0][63:0]         acts;
    qdot_pkg::lane_sum_t      psum [qdot_pkg::LANES];
    qdot_pkg::ctl_t           ctl1_reg, ctl4;
    logic signed [15:0]       ws1_reg, as1_reg;
    qdot_pkg::term_t          term;

    assign wbytes    = {blk.weight_hi, blk.weight_lo};
    assign acts      = {blk.act_3, blk.act_2, blk.act_1, blk.act_0};
    assign blk.ready = adv;

    for (genvar l = 0; l < qdot_pkg::LANES; l++)
    begin : g_lane
        qdot_lane u_lane
        (
            .clk      (clk),
            .en       (adv),
            .weights  (wbytes[32*l +: 32]),
            .acts     (acts[l]),
            .psum_reg (psum[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= '{valid: blk.valid, last_block: blk.last_block, last_row: blk.last_row};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ws1_reg <= blk.weight_scale;
            as1_reg <= blk.act_scale;
        end
    end

    qdot_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .psum         (psum),
        .weight_scale (ws1_reg),
        .act_scale    (as1_reg),
        .ctl_in       (ctl1_reg),
        .term_reg     (term),
        .ctl_out      (ctl4)
    );

    qdot_accum u_accum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .term  (term),
        .ctl   (ctl4),
        .adv   (adv),
        .res   (res)
    );

endmodule
